// ----- rtl/adsr_pkg.sv -----
package adsr_pkg;

	// field and datapath widths
	localparam int LvlW    = 16;
	localparam int ElapW   = 8;
	localparam int CfgIdxW = 3;
	localparam int TimerW  = 32;
	localparam int AmpW    = 17;
	localparam int DivNW   = 33;
	localparam int DivDW   = 16;
	localparam int MulAW   = 18;
	localparam int MulBW   = 17;
	localparam int MulPW   = MulAW + MulBW;

	typedef logic [2:0]      phase_t;
	typedef logic [AmpW-1:0] amp_t;

	// Q1.16 full scale
	localparam amp_t AmpOne = 17'h10000;

	// envelope phases
	localparam phase_t PH_IDLE    = 3'd0;
	localparam phase_t PH_ATTACK  = 3'd1;
	localparam phase_t PH_DECAY   = 3'd2;
	localparam phase_t PH_SUSTAIN = 3'd3;
	localparam phase_t PH_RELEASE = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_DECAY   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SUSTAIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_RELEASE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OUT_MIN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_OUT_MAX = 3'd5;

endpackage

// ----- rtl/adsr_div.sv -----
module adsr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [adsr_pkg::DivNW-1:0]   dividend,
	input  logic [adsr_pkg::DivDW-1:0]   divisor,
	output logic                         done,
	output logic [adsr_pkg::DivNW-1:0]   quotient
);
	import adsr_pkg::*;

	localparam logic [5:0] Steps = 6'(DivNW);

	logic             busy_q;
	logic             done_q;
	logic [5:0]       cnt_q;
	logic [DivDW-1:0] rem_q;
	logic [DivDW-1:0] dsor_q;
	logic [DivNW-1:0] quo_q;

	logic [DivDW:0]   shifted;
	logic [DivDW:0]   trial;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[DivNW-1]};
	assign trial   = shifted - {1'b0, dsor_q};
	assign ge      = shifted >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= Steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dsor_q <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DivDW-1:0] : shifted[DivDW-1:0];
			quo_q <= {quo_q[DivNW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/adsr_mul.sv -----
module adsr_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [adsr_pkg::MulAW-1:0]   mcand,
	input  logic [adsr_pkg::MulBW-1:0]   mplier,
	output logic                         done,
	output logic [adsr_pkg::MulPW-1:0]   product
);
	import adsr_pkg::*;

	localparam logic [4:0] Steps = 5'(MulBW);

	logic             busy_q;
	logic             done_q;
	logic [4:0]       cnt_q;
	logic [MulAW-1:0] mc_q;
	logic [MulAW-1:0] hi_q;
	logic [MulBW-1:0] lo_q;
	logic [MulAW:0]   sum;

	// signed x unsigned shift-add, one multiplier bit per cycle
	assign sum = {hi_q[MulAW-1], hi_q} + (lo_q[0] ? {mc_q[MulAW-1], mc_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= Steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			hi_q <= '0;
			lo_q <= mplier;
		end else if (busy_q) begin
			hi_q <= sum[MulAW:1];
			lo_q <= {sum[0], lo_q[MulBW-1:1]};
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

// ----- rtl/adsr_envelope_generator_unit.sv -----
// Linear ADSR envelope generator. Each input transaction (gate, elapsed) is one
// control tick and yields exactly one output transaction (level, phase). The
// amplitude is Q1.16 (0 .. 1.0); level = out_min + floor((out_max-out_min)*amp/2^16).
// Arithmetic runs on one shared bit-serial restoring divider and one bit-serial
// multiplier. Every tick does the level multiply, and the divider also runs:
//   when out_min <= sustain_value <= out_max and out_min != out_max (sustain fraction),
//   in release with a nonzero release_time (release step),
//   in attack before the ramp completes,
//   in decay before it completes (a multiply, then a divide).
// A tick also waits while the output register still holds an untaken result.
// One tick is processed at a time; in_ready is high only between ticks, while
// the output register may still hold the previous result. The configuration
// port is always ready; write it only between ticks. Indexes beyond the six
// registers are ignored.
module adsr_envelope_generator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [adsr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [adsr_pkg::LvlW-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           gate,
	input  logic [adsr_pkg::ElapW-1:0]     elapsed,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [adsr_pkg::LvlW-1:0] level,
	output adsr_pkg::phase_t               phase
);
	import adsr_pkg::*;

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SUS    = 4'd1;   // start sustain fraction divide
	localparam logic [3:0] ST_SUS_W  = 4'd2;
	localparam logic [3:0] ST_RST    = 4'd3;   // start release step divide
	localparam logic [3:0] ST_RST_W  = 4'd4;
	localparam logic [3:0] ST_AMP    = 4'd5;   // phase decision
	localparam logic [3:0] ST_ATK_W  = 4'd6;
	localparam logic [3:0] ST_DMUL_W = 4'd7;
	localparam logic [3:0] ST_DDIV   = 4'd8;
	localparam logic [3:0] ST_DDIV_W = 4'd9;
	localparam logic [3:0] ST_LVL    = 4'd10;  // start level multiply
	localparam logic [3:0] ST_LVL_W  = 4'd11;
	localparam logic [3:0] ST_OUT    = 4'd12;

	// configuration registers
	logic        [15:0]     attack_q;
	logic        [15:0]     decay_q;
	logic signed [LvlW-1:0] sustain_q;
	logic        [15:0]     release_q;
	logic signed [LvlW-1:0] out_min_q;
	logic signed [LvlW-1:0] out_max_q;

	// envelope state
	logic [3:0]        state_q;
	phase_t            phase_q;
	amp_t              amp_q;
	logic [TimerW-1:0] timer_q;
	logic              tclr_q;        // timer restarts at this tick
	logic              out_valid_q;

	// per-tick working registers
	logic              gate_q;
	logic [ElapW-1:0]  elapsed_q;
	amp_t              sus_q;
	amp_t              rstep_q;
	logic [LvlW-1:0]   lvl_q;
	logic [LvlW-1:0]   level_q;
	phase_t            phase_out_q;

	// shared arithmetic units
	logic              div_start;
	logic [DivNW-1:0]  div_dividend;
	logic [DivDW-1:0]  div_divisor;
	logic              div_done;
	logic [DivNW-1:0]  div_quot;
	logic              mul_start;
	logic [MulAW-1:0]  mul_mcand;
	logic [MulBW-1:0]  mul_mplier;
	logic              mul_done;
	logic [MulPW-1:0]  mul_prod;

	// datapath helpers
	logic              sus_ok;
	logic [LvlW:0]     sus_num;
	logic [LvlW:0]     span;
	logic [17:0]       rst_num;
	logic              rst_need;
	logic              atk_full;
	logic              dec_full;
	amp_t              rel_base;
	amp_t              rel_amp;
	phase_t            ph_nx;
	amp_t              amp_nx;
	logic              clr_nx;
	logic [3:0]        amp_st_nx;
	logic              out_load;
	logic [TimerW-1:0] t_base;
	logic [TimerW:0]   t_sum;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// sustain fraction valid only inside a non-empty min..max range
	assign sus_ok   = (sustain_q >= out_min_q) && (sustain_q <= out_max_q) &&
	                  (out_max_q != out_min_q);
	assign sus_num  = {sustain_q[LvlW-1], sustain_q} - {out_min_q[LvlW-1], out_min_q};
	assign span     = {out_max_q[LvlW-1], out_max_q} - {out_min_q[LvlW-1], out_min_q};
	// ceil(sus / release) as floor((sus + release - 1) / release)
	assign rst_num  = {1'b0, sus_q} + {2'b00, release_q} - 18'd1;
	assign rst_need = (phase_q == PH_RELEASE) && (release_q != 16'd0);
	assign atk_full = (attack_q == 16'd0) || (timer_q >= {16'd0, attack_q});
	assign dec_full = (decay_q == 16'd0) || (timer_q >= {16'd0, decay_q});

	assign rel_base = ((amp_q == '0) || (release_q == 16'd0)) ? '0 : amp_q;
	assign rel_amp  = (rel_base > rstep_q) ? rel_base - rstep_q : '0;

	// phase decision, taken on the timer as it stood before this tick
	always_comb begin
		ph_nx     = phase_q;
		amp_nx    = amp_q;
		clr_nx    = 1'b0;
		amp_st_nx = ST_LVL;
		case (phase_q)
			PH_ATTACK: begin
				if (atk_full) begin
					amp_nx = AmpOne;
					ph_nx  = PH_DECAY;
					clr_nx = 1'b1;
				end else begin
					amp_st_nx = ST_ATK_W;
				end
				if (!gate_q) begin
					ph_nx  = PH_RELEASE;
					clr_nx = 1'b1;
				end
			end
			PH_DECAY: begin
				if (!gate_q) begin
					ph_nx  = PH_RELEASE;
					clr_nx = 1'b1;
				end else if (dec_full) begin
					amp_nx = sus_q;
					ph_nx  = PH_SUSTAIN;
					clr_nx = 1'b1;
				end else begin
					amp_st_nx = ST_DMUL_W;
				end
			end
			PH_SUSTAIN: begin
				amp_nx = sus_q;
				if (!gate_q) begin
					ph_nx  = PH_RELEASE;
					clr_nx = 1'b1;
				end
			end
			PH_RELEASE: begin
				if ((amp_q == '0) || (release_q == 16'd0)) begin
					ph_nx  = PH_IDLE;
					clr_nx = 1'b1;
				end
				if (gate_q) begin
					ph_nx  = PH_ATTACK;
					clr_nx = 1'b1;
				end
				amp_nx = rel_amp;
			end
			default: begin
				ph_nx  = PH_IDLE;
				amp_nx = '0;
				if (gate_q) begin
					ph_nx  = PH_ATTACK;
					clr_nx = 1'b1;
				end
			end
		endcase
	end

	// divider operand select
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (state_q)
			ST_SUS: begin
				div_start    = sus_ok;
				div_dividend = {1'b0, sus_num[LvlW-1:0], 16'd0};
				div_divisor  = span[LvlW-1:0];
			end
			ST_RST: begin
				div_start    = rst_need;
				div_dividend = {15'd0, rst_num};
				div_divisor  = release_q;
			end
			ST_AMP: begin
				div_start    = (phase_q == PH_ATTACK) && (amp_st_nx == ST_ATK_W);
				div_dividend = {1'b0, timer_q[15:0], 16'd0};
				div_divisor  = attack_q;
			end
			ST_DDIV: begin
				div_start    = 1'b1;
				div_dividend = mul_prod[DivNW-1:0];
				div_divisor  = decay_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// multiplier operand select
	always_comb begin
		mul_start  = 1'b0;
		mul_mcand  = '0;
		mul_mplier = '0;
		case (state_q)
			ST_AMP: begin
				mul_start  = (amp_st_nx == ST_DMUL_W);
				mul_mcand  = {1'b0, AmpOne - sus_q};
				mul_mplier = {1'b0, timer_q[15:0]};
			end
			ST_LVL: begin
				mul_start  = 1'b1;
				mul_mcand  = {span[LvlW], span};
				mul_mplier = amp_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	// timer: restart if flagged, then advance by elapsed outside idle, saturating
	assign t_base = tclr_q ? '0 : timer_q;
	assign t_sum  = {1'b0, t_base} + {{(TimerW+1-ElapW){1'b0}}, elapsed_q};

	adsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	adsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.done    (mul_done),
		.product (mul_prod)
	);

	// control and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q    <= 16'd0;
			decay_q     <= 16'd0;
			sustain_q   <= 16'sd1;
			release_q   <= 16'd0;
			out_min_q   <= 16'sd0;
			out_max_q   <= 16'sd32767;
			state_q     <= ST_IDLE;
			phase_q     <= PH_IDLE;
			amp_q       <= '0;
			timer_q     <= '0;
			tclr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTACK:  attack_q  <= cfg_data;
					REG_DECAY:   decay_q   <= cfg_data;
					REG_SUSTAIN: sustain_q <= cfg_data;
					REG_RELEASE: release_q <= cfg_data;
					REG_OUT_MIN: out_min_q <= cfg_data;
					REG_OUT_MAX: out_max_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tclr_q  <= 1'b0;
						state_q <= ST_SUS;
					end
				end
				ST_SUS:    state_q <= sus_ok ? ST_SUS_W : ST_RST;
				ST_SUS_W:  if (div_done) state_q <= ST_RST;
				ST_RST:    state_q <= rst_need ? ST_RST_W : ST_AMP;
				ST_RST_W:  if (div_done) state_q <= ST_AMP;
				ST_AMP: begin
					phase_q <= ph_nx;
					amp_q   <= amp_nx;
					tclr_q  <= clr_nx;
					state_q <= amp_st_nx;
				end
				ST_ATK_W: begin
					if (div_done) begin
						amp_q   <= div_quot[AmpW-1:0];
						state_q <= ST_LVL;
					end
				end
				ST_DMUL_W: if (mul_done) state_q <= ST_DDIV;
				ST_DDIV:   state_q <= ST_DDIV_W;
				ST_DDIV_W: begin
					if (div_done) begin
						amp_q   <= AmpOne - div_quot[AmpW-1:0];
						state_q <= ST_LVL;
					end
				end
				ST_LVL:    state_q <= ST_LVL_W;
				ST_LVL_W:  if (mul_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (phase_q != PH_IDLE) begin
							timer_q <= t_sum[TimerW] ? '1 : t_sum[TimerW-1:0];
						end else begin
							timer_q <= t_base;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-tick payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			gate_q    <= gate;
			elapsed_q <= elapsed;
		end
		if (state_q == ST_SUS && !sus_ok) begin
			sus_q <= '0;
		end else if (state_q == ST_SUS_W && div_done) begin
			sus_q <= div_quot[AmpW-1:0];
		end
		if (state_q == ST_RST && !rst_need) begin
			rstep_q <= '0;
		end else if (state_q == ST_RST_W && div_done) begin
			rstep_q <= div_quot[AmpW-1:0];
		end
		// floor of product / 2^16 plus out_min, kept to the output width
		if (state_q == ST_LVL_W && mul_done) begin
			lvl_q <= mul_prod[16 +: LvlW] + out_min_q;
		end
		if (out_load) begin
			level_q     <= lvl_q;
			phase_out_q <= phase_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase     = phase_out_q;

	// only one tick in flight
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a tick is in flight");

	// amplitude never exceeds full scale
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		amp_q <= AmpOne)
		else $error("amplitude above 1.0");

	// divider results arrive only while the sequencer waits for them
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_SUS_W || state_q == ST_RST_W ||
		              state_q == ST_ATK_W || state_q == ST_DDIV_W))
		else $error("divider finished outside a wait state");

	// a finished tick always lands in the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid && state_q == ST_IDLE))
		else $error("result not presented after completion");

endmodule
